/* hdl/integer_matrix_multiply_defines.svh */
// Assertion macros used by the checker.
`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH

// Consequence holds in the cycle after the antecedent.
`define IMM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("imm: next-cycle check failed");

// Consequence holds in the same cycle as the antecedent.
`define IMM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("imm: same-cycle check failed");

`endif

/* hdl/imm_pkg.sv */
package imm_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int DIM_W       = 4;
	localparam int REG_IDX_W   = 2;

	localparam logic [REG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_B_COLS    = 2'd2;

	typedef enum logic [1:0] {
		FUNC_LOAD_A  = 2'd0,
		FUNC_LOAD_B  = 2'd1,
		FUNC_COMPUTE = 2'd2
	} func_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		func_t              func;
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         out_row;
		logic [2:0]         out_col;
		logic signed [63:0] sum;
		logic               last;
	} out_item_t;

	// control travelling alongside each multiply-accumulate step
	typedef struct packed {
		logic       v;
		logic       first;
		logic       lastk;
		logic       last;
		logic [2:0] row;
		logic [2:0] col;
	} mac_ctl_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int max_dim);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (int'(v) > max_dim)
			r = DIM_W'(max_dim);
		return r;
	endfunction

endpackage

/* hdl/integer_matrix_multiply.sv */
// Integer matrix multiplier, C = A * B, signed 32-bit elements, 64-bit wrapping sums.
// A load item (func load A / load B) writes one element; loads outside the
// configured sizes are dropped. A compute item walks i, j, k and issues one
// multiply-accumulate per cycle, one read of each matrix memory per step, and holds the
// input closed while it walks. Each step's operands pass the read and product registers
// before the sum is taken into the result register; no further item is taken until
// its last read has been issued. Results leave in row-major order with last set on the
// final one, and a stalled result stalls the walk for as long as it waits.
// The matrix memories are not cleared: every element must be loaded before it is used.
// The user must write sizes on the wr_* port only while idle; the block does not enforce it.
module integer_matrix_multiply #(
	parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  imm_pkg::in_item_t               item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output imm_pkg::out_item_t              result,
	input  logic                            wr_en,
	input  logic [imm_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [imm_pkg::DIM_W-1:0]       wr_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DW    = imm_pkg::DIM_W;

	logic signed [31:0] mem_a [DEPTH];
	logic signed [31:0] mem_b [DEPTH];

	logic [DW-1:0] a_rows_q, inner_q, b_cols_q;

	imm_pkg::state_t state_q, state_d;
	logic [IW-1:0] i_q, j_q, k_q, i_d, j_d, k_d;

	logic adv, issue, accept, end_k, end_j, end_i;
	logic [AW-1:0] a_raddr, b_raddr, waddr;
	logic a_in_range, b_in_range;

	logic signed [31:0] a_rd_s1, b_rd_s1;
	logic signed [63:0] prod_s2, acc_q, acc_next;
	imm_pkg::mac_ctl_t  ctl_is, ctl_s1, ctl_s2;

	logic      out_valid_q;
	imm_pkg::out_item_t out_q;

	assign adv        = !out_valid_q || result_ready;
	assign item_ready = (state_q == imm_pkg::ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign issue      = (state_q == imm_pkg::ST_RUN) && adv;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= imm_pkg::clamp_dim(DW'(8), MAX_DIM);
			inner_q  <= imm_pkg::clamp_dim(DW'(8), MAX_DIM);
			b_cols_q <= imm_pkg::clamp_dim(DW'(8), MAX_DIM);
		end else if (wr_en) begin
			case (wr_index)
				imm_pkg::REG_A_ROWS:    a_rows_q <= imm_pkg::clamp_dim(wr_data, MAX_DIM);
				imm_pkg::REG_INNER_LEN: inner_q  <= imm_pkg::clamp_dim(wr_data, MAX_DIM);
				imm_pkg::REG_B_COLS:    b_cols_q <= imm_pkg::clamp_dim(wr_data, MAX_DIM);
				default: ;
			endcase
		end
	end

	// load path
	assign waddr      = AW'(8'(item.row) * 8'(MAX_DIM) + 8'(item.col));
	assign a_in_range = (DW'(item.row) < a_rows_q) && (DW'(item.col) < inner_q);
	assign b_in_range = (DW'(item.row) < inner_q) && (DW'(item.col) < b_cols_q);

	always_ff @(posedge clk) begin
		if (accept && item.func == imm_pkg::FUNC_LOAD_A && a_in_range)
			mem_a[waddr] <= item.value;
	end

	always_ff @(posedge clk) begin
		if (accept && item.func == imm_pkg::FUNC_LOAD_B && b_in_range)
			mem_b[waddr] <= item.value;
	end

	// walk sequencer
	assign end_k = (DW'(k_q) == inner_q - DW'(1));
	assign end_j = (DW'(j_q) == b_cols_q - DW'(1));
	assign end_i = (DW'(i_q) == a_rows_q - DW'(1));

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		case (state_q)
			imm_pkg::ST_IDLE: begin
				if (accept && item.func == imm_pkg::FUNC_COMPUTE) begin
					state_d = imm_pkg::ST_RUN;
					i_d     = '0;
					j_d     = '0;
					k_d     = '0;
				end
			end
			imm_pkg::ST_RUN: begin
				if (adv) begin
					k_d = k_q + IW'(1);
					if (end_k) begin
						k_d = '0;
						j_d = j_q + IW'(1);
						if (end_j) begin
							j_d = '0;
							i_d = i_q + IW'(1);
							if (end_i)
								state_d = imm_pkg::ST_IDLE;
						end
					end
				end
			end
			default: state_d = imm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imm_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	// read stage
	assign a_raddr = AW'(8'(i_q) * 8'(MAX_DIM) + 8'(k_q));
	assign b_raddr = AW'(8'(k_q) * 8'(MAX_DIM) + 8'(j_q));

	always_comb begin
		ctl_is.v     = issue;
		ctl_is.first = (k_q == '0);
		ctl_is.lastk = end_k;
		ctl_is.last  = end_k && end_j && end_i;
		ctl_is.row   = 3'(i_q);
		ctl_is.col   = 3'(j_q);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_rd_s1 <= mem_a[a_raddr];
			b_rd_s1 <= mem_b[b_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_is;
			ctl_s2 <= ctl_s1;
		end
	end

	// multiply, then accumulate
	always_ff @(posedge clk) begin
		if (adv)
			prod_s2 <= 64'(a_rd_s1) * 64'(b_rd_s1);
	end

	assign acc_next = ctl_s2.first ? prod_s2 : acc_q + prod_s2;

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.v)
			acc_q <= acc_next;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= ctl_s2.v && ctl_s2.lastk;
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.v && ctl_s2.lastk) begin
			out_q.out_row <= ctl_s2.row;
			out_q.out_col <= ctl_s2.col;
			out_q.sum     <= acc_next;
			out_q.last    <= ctl_s2.last;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* hdl/imm_checker.sv */
`include "integer_matrix_multiply_defines.svh"

module imm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input imm_pkg::in_item_t             item,
	input logic                          result_valid,
	input logic                          result_ready,
	input imm_pkg::out_item_t            result,
	input logic                          wr_en
);

	logic load_acc, comp_acc;

	assign load_acc = item_valid && item_ready && (item.func != imm_pkg::FUNC_COMPUTE);
	assign comp_acc = item_valid && item_ready && (item.func == imm_pkg::FUNC_COMPUTE);

	// a held result keeps its payload
	`IMM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// a compute run blocks new items
	`IMM_ASSERT_NEXT(a_compute_busy, comp_acc, !item_ready)

	// loads never close the input
	`IMM_ASSERT_NEXT(a_load_stream, load_acc, item_ready)

	// sizes change only while the block is idle and holds no result
	`IMM_ASSERT_NOW(a_cfg_idle, wr_en, item_ready && !result_valid)

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.wr_en        (wr_en)
);

/* tb/sv/tb_integer_matrix_multiply.sv */
module tb_integer_matrix_multiply;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM = 8;
	localparam int SETTLE_CYCLES = 10;
	localparam int ITEM_TARGET = 410;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	imm_pkg::in_item_t item;
	logic result_valid;
	logic result_ready;
	imm_pkg::out_item_t result;
	logic wr_en;
	logic [imm_pkg::REG_IDX_W-1:0] wr_index;
	logic [imm_pkg::DIM_W-1:0] wr_data;

	// shadow of the block's matrices and sizes
	logic signed [31:0] a_mem [DIM*DIM];
	logic signed [31:0] b_mem [DIM*DIM];
	bit a_loaded [DIM*DIM];
	bit b_loaded [DIM*DIM];
	int dim_rows = DIM;
	int dim_inner = DIM;
	int dim_cols = DIM;

	imm_pkg::out_item_t expected_c[$];

	bit steady;
	int n_items;
	int n_effective;
	int n_computes;
	int n_results;
	int n_writes;
	int n_errors;

	integer_matrix_multiply #(
		.MAX_DIM(DIM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #5 clk = ~clk;

	task automatic flag_error(input string what);
		n_errors++;
		if (n_errors <= 30)
			$display("ERROR %0t ns: %s", $time, what);
	endtask

	function automatic int eff_dim(input logic [imm_pkg::DIM_W-1:0] raw);
		if (raw == '0)
			return 1;
		if (int'(raw) > DIM)
			return DIM;
		return int'(raw);
	endfunction

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3: return 32'sd0;
			4, 5: return 32'(int'($urandom_range(0, 31)) - 16);
			default: return $urandom;
		endcase
	endfunction

	task automatic predict_product();
		logic signed [63:0] acc;
		logic signed [63:0] ax;
		logic signed [63:0] bx;
		imm_pkg::out_item_t r;
		for (int i = 0; i < dim_rows; i++) begin
			for (int j = 0; j < dim_cols; j++) begin
				acc = '0;
				for (int k = 0; k < dim_inner; k++) begin
					ax = a_mem[i*DIM + k];
					bx = b_mem[k*DIM + j];
					acc = acc + ax * bx;
				end
				r.out_row = 3'(i);
				r.out_col = 3'(j);
				r.sum = acc;
				r.last = (i == dim_rows - 1) && (j == dim_cols - 1);
				expected_c.push_back(r);
			end
		end
	endtask

	task automatic apply_item(input imm_pkg::in_item_t it);
		int r;
		int c;
		r = int'(it.row);
		c = int'(it.col);
		case (it.func)
			imm_pkg::FUNC_LOAD_A: begin
				if (r < dim_rows && c < dim_inner) begin
					a_mem[r*DIM + c] = it.value;
					a_loaded[r*DIM + c] = 1'b1;
					n_effective++;
				end
			end
			imm_pkg::FUNC_LOAD_B: begin
				if (r < dim_inner && c < dim_cols) begin
					b_mem[r*DIM + c] = it.value;
					b_loaded[r*DIM + c] = 1'b1;
					n_effective++;
				end
			end
			imm_pkg::FUNC_COMPUTE: begin
				predict_product();
				n_effective++;
				n_computes++;
			end
			default: ;
		endcase
	endtask

	// called at a falling edge; returns at a falling edge with valid still high
	task automatic send_item(input imm_pkg::func_t f, input logic [2:0] row,
			input logic [2:0] col, input logic signed [31:0] v);
		imm_pkg::in_item_t it;
		it.func = f;
		it.row = row;
		it.col = col;
		it.value = v;
		while (!steady && $urandom_range(0, 99) < 35) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		apply_item(it);
		n_items++;
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (expected_c.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_size(input logic [imm_pkg::REG_IDX_W-1:0] idx,
			input logic [imm_pkg::DIM_W-1:0] raw);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= raw;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			imm_pkg::REG_A_ROWS: dim_rows = eff_dim(raw);
			imm_pkg::REG_INNER_LEN: dim_inner = eff_dim(raw);
			imm_pkg::REG_B_COLS: dim_cols = eff_dim(raw);
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
	endtask

	task automatic set_sizes(input logic [imm_pkg::DIM_W-1:0] ra,
			input logic [imm_pkg::DIM_W-1:0] rk, input logic [imm_pkg::DIM_W-1:0] rb);
		drain();
		write_size(imm_pkg::REG_A_ROWS, ra);
		write_size(imm_pkg::REG_INNER_LEN, rk);
		write_size(imm_pkg::REG_B_COLS, rb);
	endtask

	// load whatever the next compute would read but has never been written, then issue the compute
	task automatic compute_now();
		for (int r = 0; r < dim_rows; r++)
			for (int c = 0; c < dim_inner; c++)
				if (!a_loaded[r*DIM + c])
					send_item(imm_pkg::FUNC_LOAD_A, 3'(r), 3'(c), rand_value());
		for (int r = 0; r < dim_inner; r++)
			for (int c = 0; c < dim_cols; c++)
				if (!b_loaded[r*DIM + c])
					send_item(imm_pkg::FUNC_LOAD_B, 3'(r), 3'(c), rand_value());
		send_item(imm_pkg::FUNC_COMPUTE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
			$urandom);
	endtask

	task automatic test_directed();
		set_sizes(4'd2, 4'd2, 4'd2);
		send_item(imm_pkg::FUNC_LOAD_A, 3'd0, 3'd0, 32'sh8000_0000);
		send_item(imm_pkg::FUNC_LOAD_A, 3'd0, 3'd1, 32'sh8000_0000);
		send_item(imm_pkg::FUNC_LOAD_A, 3'd1, 3'd0, 32'sh7fff_ffff);
		send_item(imm_pkg::FUNC_LOAD_A, 3'd1, 3'd1, -32'sd1);
		send_item(imm_pkg::FUNC_LOAD_B, 3'd0, 3'd0, 32'sh8000_0000);
		send_item(imm_pkg::FUNC_LOAD_B, 3'd1, 3'd0, 32'sh8000_0000);
		send_item(imm_pkg::FUNC_LOAD_B, 3'd0, 3'd1, 32'sh7fff_ffff);
		send_item(imm_pkg::FUNC_LOAD_B, 3'd1, 3'd1, 32'sd0);
		// loads outside the sizes are dropped
		send_item(imm_pkg::FUNC_LOAD_A, 3'd2, 3'd0, 32'sd5);
		send_item(imm_pkg::FUNC_LOAD_A, 3'd0, 3'd7, 32'sd6);
		send_item(imm_pkg::FUNC_LOAD_B, 3'd7, 3'd1, 32'sd7);
		send_item(imm_pkg::FUNC_LOAD_B, 3'd0, 3'd2, 32'sd8);
		send_item(imm_pkg::func_t'(FUNC_UNUSED), 3'd7, 3'd7, 32'shffff_ffff);
		send_item(imm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 32'sd0);
		drain();
		send_item(imm_pkg::FUNC_LOAD_A, 3'd1, 3'd1, 32'sd7);
		send_item(imm_pkg::FUNC_COMPUTE, 3'd7, 3'd7, 32'sd0);
	endtask

	task automatic test_size_extremes();
		logic [imm_pkg::DIM_W-1:0] ra [6] = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd0, 4'd3};
		logic [imm_pkg::DIM_W-1:0] rk [6] = '{4'd0, 4'd15, 4'd8, 4'd1, 4'd15, 4'd12};
		logic [imm_pkg::DIM_W-1:0] rb [6] = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd9, 4'd0};
		for (int p = 0; p < 6; p++) begin
			set_sizes(ra[p], rk[p], rb[p]);
			steady = (p == 1);
			compute_now();
		end
		steady = 1'b0;
	endtask

	task automatic random_phase();
		logic [imm_pkg::DIM_W-1:0] raw [3];
		int pick;
		for (int r = 0; r < 3; r++)
			raw[r] = ($urandom_range(0, 9) < 8) ? imm_pkg::DIM_W'($urandom_range(0, 4))
				: imm_pkg::DIM_W'($urandom_range(5, 15));
		set_sizes(raw[0], raw[1], raw[2]);
		repeat ($urandom_range(6, 20)) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				send_item(imm_pkg::FUNC_LOAD_A, 3'($urandom_range(0, dim_rows - 1)),
					3'($urandom_range(0, dim_inner - 1)), rand_value());
			else if (pick < 60)
				send_item(imm_pkg::FUNC_LOAD_B, 3'($urandom_range(0, dim_inner - 1)),
					3'($urandom_range(0, dim_cols - 1)), rand_value());
			else if (pick < 72)
				send_item(pick[0] ? imm_pkg::FUNC_LOAD_B : imm_pkg::FUNC_LOAD_A,
					3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), rand_value());
			else if (pick < 76)
				send_item(imm_pkg::func_t'(FUNC_UNUSED), 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)), $urandom);
			else if (pick < 92)
				compute_now();
			else begin
				compute_now();
				drain();
			end
		end
		compute_now();
	endtask

	task automatic test_random();
		int phase;
		phase = 0;
		while (n_items < ITEM_TARGET) begin
			steady = (phase >= 2 && phase <= 4);
			random_phase();
			phase++;
		end
		steady = 1'b0;
	endtask

	always @(negedge clk)
		result_ready <= steady || ($urandom_range(0, 99) >= 35);

	always @(posedge clk) begin : check_results
		imm_pkg::out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			n_results++;
			if (expected_c.size() == 0)
				flag_error($sformatf("result with nothing expected: row %0d col %0d",
					result.out_row, result.out_col));
			else begin
				want = expected_c.pop_front();
				if (result.out_row !== want.out_row)
					flag_error($sformatf("out_row %0d, expected %0d",
						result.out_row, want.out_row));
				if (result.out_col !== want.out_col)
					flag_error($sformatf("out_col %0d, expected %0d",
						result.out_col, want.out_col));
				if (result.sum !== want.sum)
					flag_error($sformatf("sum at (%0d,%0d) %0d, expected %0d", want.out_row,
						want.out_col, result.sum, want.sum));
				if (result.last !== want.last)
					flag_error($sformatf("last at (%0d,%0d) %b, expected %b", want.out_row,
						want.out_col, result.last, want.last));
			end
		end
	end

	initial begin
		#50_000_000;
		$display("FAIL integer_matrix_multiply");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		wr_en = 1'b0;
		wr_index = imm_pkg::REG_A_ROWS;
		wr_data = '0;
		steady = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_size_extremes();
		test_random();
		drain();

		$display("Ran %0d items (%0d taking effect, %0d computes) across %0d size writes;",
			n_items, n_effective, n_computes, n_writes);
		$display("checked %0d result elements, %0d mismatches.", n_results, n_errors);
		if (n_errors == 0)
			$display("PASS integer_matrix_multiply");
		else
			$display("FAIL integer_matrix_multiply");
		$finish;
	end

endmodule
